// File: hw/rtl/tcw_pkg.sv
// Package: shared types, constants and codes for the text console cell writer.
`default_nettype none

package tcw_pkg;

    // Grid geometry
    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = ROWS * COLUMNS;
    localparam int ADDR_W  = $clog2(CELLS);
    localparam int COL_W   = 7;
    localparam int ROW_W   = 5;
    localparam int CELL_W  = 16;

    // Sweep bounds for the scroll
    localparam int COPY_LAST  = (ROWS - 1) * COLUMNS - 1;
    localparam int FILL_FIRST = (ROWS - 1) * COLUMNS;

    // Request queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Command codes
    localparam logic [1:0] CMD_PUT   = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    // Character codes and cell constants
    localparam logic [7:0]        CH_NEWLINE  = 8'h0A;
    localparam logic [7:0]        CH_RETURN   = 8'h0D;
    localparam logic [CELL_W-1:0] CELL_BLANK  = 16'h0020;
    localparam logic [CELL_W-1:0] CELL_SCROLL = 16'h0720;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] char_code;
        logic [7:0] attr;
        logic [4:0] read_row;
        logic [6:0] read_col;
    } request_t;

    typedef struct packed {
        logic [CELL_W-1:0] cell_value;
        logic [COL_W-1:0]  cursor_x;
        logic [ROW_W-1:0]  cursor_y;
    } result_t;

    // Classified operation handed from front to back
    typedef enum logic [2:0] {
        OP_PUT,
        OP_NEWLINE,
        OP_RETURN,
        OP_READ,
        OP_CLEAR,
        OP_NONE
    } op_kind_t;

    typedef struct packed {
        op_kind_t          kind;
        logic [CELL_W-1:0] cell_data;
        logic [ADDR_W-1:0] addr;
    } op_t;

    // Back-end sequencer states
    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_SCROLL_COPY,
        ST_SCROLL_FILL,
        ST_EXEC,
        ST_READ_WAIT,
        ST_CLEAR_FILL
    } state_t;

endpackage

`default_nettype wire

// File: hw/rtl/tcw_front.sv
// Front end: request acceptance and command classification.
`default_nettype none

module tcw_front
    import tcw_pkg::*;
(
    input  wire logic     start,
    input  wire request_t request,
    input  wire logic     queue_full,
    input  wire logic     init_busy,
    output logic          busy,
    output logic          push,
    output op_t           op
);

    // Hold off while the queue is full or the grid is being cleared after reset
    assign busy = queue_full | init_busy;
    assign push = start & ~busy;

    // Classify the request and precompute the cell and read address
    always_comb
    begin
        op.kind      = OP_NONE;
        op.cell_data = {request.attr, request.char_code};
        op.addr      = ADDR_W'(32'(request.read_row) * COLUMNS + 32'(request.read_col));
        case (request.cmd)
            CMD_PUT:
            begin
                if (request.char_code == CH_NEWLINE)
                    op.kind = OP_NEWLINE;
                else if (request.char_code == CH_RETURN)
                    op.kind = OP_RETURN;
                else
                    op.kind = OP_PUT;
            end
            CMD_READ:
            begin
                // out-of-grid reads return zero and touch nothing
                if (32'(request.read_row) < ROWS && 32'(request.read_col) < COLUMNS)
                    op.kind = OP_READ;
            end
            CMD_CLEAR:
                op.kind = OP_CLEAR;
            default:
                op.kind = OP_NONE;
        endcase
    end

endmodule

`default_nettype wire

// File: hw/rtl/tcw_queue.sv
// Short FIFO of classified operations between front and back.
`default_nettype none

module tcw_queue
    import tcw_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire op_t  push_op,
    input  wire logic pop,
    output op_t       pop_op,
    output logic      full,
    output logic      empty
);

    op_t               entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full   = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty  = (count_reg == '0);
    assign pop_op = entry_reg[rd_ptr_reg];

    // Pointer and fill-level update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_op;
    end

endmodule

`default_nettype wire

// File: hw/rtl/tcw_back.sv
// Back end: cell memory, cursor, scroll/clear sweeps and result generation.
`default_nettype none

module tcw_back
    import tcw_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic queue_empty,
    input  wire op_t  queue_op,
    output logic      pop,
    output logic      init_busy,
    output logic      done,
    output result_t   result
);

    // Cell memory, one write and one registered read port
    logic [CELL_W-1:0] mem [CELLS];
    logic [CELL_W-1:0] rd_data_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [CELL_W-1:0] mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;

    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] cnt_reg, cnt_next;
    logic              pend_reg, pend_next;
    logic [ADDR_W-1:0] pend_addr_reg, pend_addr_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    op_t               op_reg, op_next;
    logic              done_reg, done_next;
    result_t           result_reg, result_next;
    logic [CELL_W-1:0] cell_next;
    logic [ADDR_W-1:0] cursor_addr;

    assign init_busy = (state_reg == ST_INIT);
    assign done      = done_reg;
    assign result    = result_reg;

    assign cursor_addr = ADDR_W'(32'(row_reg) * COLUMNS + 32'(col_reg));

    // Sequencer: next state, cursor and memory port control
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        pend_next      = 1'b0;
        pend_addr_next = pend_addr_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        op_next        = op_reg;
        done_next      = 1'b0;
        cell_next      = '0;
        pop            = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = pend_addr_reg;
        mem_wdata      = rd_data_reg;
        mem_re         = 1'b0;
        mem_raddr      = cnt_reg + ADDR_W'(COLUMNS);

        // finish the copy of a cell read in the previous cycle
        if (pend_reg)
            mem_we = 1'b1;

        unique case (state_reg)
            ST_INIT:
            begin
                mem_we    = 1'b1;
                mem_waddr = cnt_reg;
                mem_wdata = CELL_BLANK;
                if (cnt_reg == ADDR_W'(CELLS - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            ST_IDLE:
            begin
                if (!queue_empty)
                begin
                    pop     = 1'b1;
                    op_next = queue_op;
                    if (32'(row_reg) == ROWS)
                    begin
                        cnt_next   = '0;
                        state_next = ST_SCROLL_COPY;
                    end
                    else
                        state_next = ST_EXEC;
                end
            end
            ST_SCROLL_COPY:
            begin
                // read the cell one row down, write it back next cycle
                mem_re         = 1'b1;
                mem_raddr      = cnt_reg + ADDR_W'(COLUMNS);
                pend_next      = 1'b1;
                pend_addr_next = cnt_reg;
                if (cnt_reg == ADDR_W'(COPY_LAST))
                begin
                    cnt_next   = ADDR_W'(FILL_FIRST);
                    state_next = ST_SCROLL_FILL;
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            ST_SCROLL_FILL:
            begin
                // the last pending copy owns the write port first
                if (!pend_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = cnt_reg;
                    mem_wdata = CELL_SCROLL;
                    if (cnt_reg == ADDR_W'(CELLS - 1))
                    begin
                        cnt_next   = '0;
                        row_next   = ROW_W'(ROWS - 1);
                        state_next = ST_EXEC;
                    end
                    else
                        cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_EXEC:
            begin
                unique case (op_reg.kind)
                    OP_PUT:
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = cursor_addr;
                        mem_wdata = op_reg.cell_data;
                        if (32'(col_reg) == COLUMNS - 1)
                        begin
                            col_next = '0;
                            row_next = row_reg + 1'b1;
                        end
                        else
                            col_next = col_reg + 1'b1;
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                    OP_NEWLINE:
                    begin
                        col_next   = '0;
                        row_next   = row_reg + 1'b1;
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                    OP_RETURN:
                    begin
                        col_next   = '0;
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                    OP_READ:
                    begin
                        mem_re     = 1'b1;
                        mem_raddr  = op_reg.addr;
                        state_next = ST_READ_WAIT;
                    end
                    OP_CLEAR:
                    begin
                        cnt_next   = '0;
                        state_next = ST_CLEAR_FILL;
                    end
                    OP_NONE:
                    begin
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                    default:
                    begin
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_READ_WAIT:
            begin
                cell_next  = rd_data_reg;
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            ST_CLEAR_FILL:
            begin
                mem_we    = 1'b1;
                mem_waddr = cnt_reg;
                mem_wdata = CELL_BLANK;
                if (cnt_reg == ADDR_W'(CELLS - 1))
                begin
                    cnt_next   = '0;
                    col_next   = '0;
                    row_next   = '0;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            default:
                state_next = ST_IDLE;
        endcase

        // result carries the cursor after the item
        result_next = result_reg;
        if (done_next)
        begin
            result_next.cell_value = cell_next;
            result_next.cursor_x   = col_next;
            result_next.cursor_y   = row_next;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
            cnt_reg   <= '0;
            pend_reg  <= 1'b0;
            col_reg   <= '0;
            row_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            pend_reg  <= pend_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            done_reg  <= done_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        pend_addr_reg <= pend_addr_next;
        op_reg        <= op_next;
        result_reg    <= result_next;
    end

    // Memory ports
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rd_data_reg <= mem[mem_raddr];
    end

endmodule

`default_nettype wire

// File: hw/rtl/text_console_cell_writer_unit.sv
// Top level: text console cell writer, front end, request queue and back end.
// Flow: a request is pushed into the queue, popped by the back end in its idle state and
//   carried out in the execute state, with done registered; a read adds a read-wait state,
//   a clear sweeps every cell and a pending scroll adds a copy sweep and a fill sweep first.
// The back end takes one item at a time through its dequeue and execute states and its
//   single memory write port; a 2-entry queue takes requests meanwhile.
// Reset: a clearing pass over all ROWS*COLUMNS cells of the cell memory with busy high.
// Results are strobed for one cycle on done; the receiver cannot stall.
`default_nettype none

module text_console_cell_writer_unit
    import tcw_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    output logic          busy,
    input  wire request_t request,
    output logic          done,
    output result_t       result
);

    logic queue_full;
    logic queue_empty;
    logic init_busy;
    logic push;
    logic pop;
    op_t  push_op;
    op_t  pop_op;

    tcw_front u_front (
        .start      (start),
        .request    (request),
        .queue_full (queue_full),
        .init_busy  (init_busy),
        .busy       (busy),
        .push       (push),
        .op         (push_op)
    );

    tcw_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .pop     (pop),
        .pop_op  (pop_op),
        .full    (queue_full),
        .empty   (queue_empty)
    );

    tcw_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (queue_empty),
        .queue_op    (pop_op),
        .pop         (pop),
        .init_busy   (init_busy),
        .done        (done),
        .result      (result)
    );

endmodule

`default_nettype wire

// File: hw/rtl/tcw_checker.sv
// Port-level checker for the text console cell writer, bound to the top level.
`default_nettype none

module tcw_checker
    import tcw_pkg::*;
(
    input wire logic     clk,
    input wire logic     rst_n,
    input wire logic     start,
    input wire logic     busy,
    input wire request_t request,
    input wire logic     done,
    input wire result_t  result
);

    // Cursor row never runs past the pending-scroll value
    a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (32'(result.cursor_y) <= ROWS))
        else $error("cursor row beyond grid");

    // Cursor column always inside a line
    a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (32'(result.cursor_x) < COLUMNS))
        else $error("cursor column beyond line");

    // Each item passes through the idle dequeue state, so results never come back to back
    a_done_gap: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobes in consecutive cycles");

    // The block refuses requests while the post-reset clearing pass runs
    a_busy_after_reset: assert property (@(posedge clk)
        !rst_n |=> busy)
        else $error("not busy right after reset");

    // An accepted request carries known field values
    a_request_known: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> !$isunknown(request))
        else $error("accepted request has unknown bits");

endmodule

bind text_console_cell_writer_unit tcw_checker u_tcw_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result)
);

`default_nettype wire

// File: sim/text_console_cell_writer_checker.sv
// Checker: watches request and result traffic of the console writer and compares results.
`timescale 1ns / 100ps

module text_console_cell_writer_checker
    import tcw_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    input  wire logic busy,
    input  request_t  request,
    input  wire logic done,
    input  result_t   result,
    output int        failures,
    output int        pending
);

    // Shadow copy of the screen and cursor
    logic [CELL_W-1:0] screen [0:CELLS-1];
    int                cur_col;
    int                cur_row;
    result_t           expected_q [$];

    function automatic void fill_screen(logic [CELL_W-1:0] value);
        for (int k = 0; k < CELLS; k++)
            screen[k] = value;
    endfunction

    // Applies one request to the shadow state and returns the result it should produce
    function automatic result_t console_step(request_t req);
        result_t res;
        res = '0;
        // a pending scroll is taken before any command
        if (cur_row >= ROWS)
        begin
            for (int k = 0; k <= COPY_LAST; k++)
                screen[k] = screen[k + COLUMNS];
            for (int k = FILL_FIRST; k < CELLS; k++)
                screen[k] = CELL_SCROLL;
            cur_row = ROWS - 1;
        end
        case (req.cmd)
            CMD_PUT:
            begin
                if (req.char_code == CH_NEWLINE)
                begin
                    cur_col = 0;
                    cur_row++;
                end
                else if (req.char_code == CH_RETURN)
                begin
                    cur_col = 0;
                end
                else
                begin
                    if (cur_row < ROWS && cur_col < COLUMNS)
                        screen[cur_row * COLUMNS + cur_col] = {req.attr, req.char_code};
                    cur_col++;
                    if (cur_col >= COLUMNS)
                    begin
                        cur_col = 0;
                        cur_row++;
                    end
                end
            end
            CMD_READ:
            begin
                // out-of-grid reads return zero
                if (req.read_row < ROWS && req.read_col < COLUMNS)
                    res.cell_value = screen[int'(req.read_row) * COLUMNS + int'(req.read_col)];
            end
            CMD_CLEAR:
            begin
                fill_screen(CELL_BLANK);
                cur_col = 0;
                cur_row = 0;
            end
            default: ;
        endcase
        res.cursor_x = cur_col[COL_W-1:0];
        res.cursor_y = cur_row[ROW_W-1:0];
        return res;
    endfunction

    // Compare results first (they always belong to older requests), then log the new request
    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            fill_screen(CELL_BLANK);
            cur_col = 0;
            cur_row = 0;
            expected_q.delete();
            failures = 0;
            pending <= 0;
        end
        else
        begin
            if (done)
            begin
                if (expected_q.size() == 0)
                begin
                    if (failures < 10)
                        $display("%0t: result with no request outstanding: cell %h x %0d y %0d",
                                 $realtime, result.cell_value, result.cursor_x, result.cursor_y);
                    failures++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (want.cell_value !== result.cell_value || want.cursor_x !== result.cursor_x
                        || want.cursor_y !== result.cursor_y)
                    begin
                        if (failures < 10)
                            $display("%0t: mismatch: expected cell %h x %0d y %0d, got cell %h x %0d y %0d",
                                     $realtime, want.cell_value, want.cursor_x, want.cursor_y,
                                     result.cell_value, result.cursor_x, result.cursor_y);
                        failures++;
                    end
                end
            end
            if (start && !busy)
                expected_q.push_back(console_step(request));
            pending <= expected_q.size();
        end
    end

endmodule

// File: sim/text_console_cell_writer_unit_test.sv
// Testbench top: clock, reset, request stimulus and verdict for the console writer.
`timescale 1ns / 100ps

module text_console_cell_writer_unit_test;
    import tcw_pkg::*;

    localparam logic [1:0] CMD_UNUSED  = 2'd3;
    localparam int         ITEM_TARGET = 1950;
    localparam int         TAIL_START  = 1750;

    logic     clk = 1'b0;
    logic     rst_n;
    logic     start;
    logic     busy;
    logic     done;
    request_t request;
    result_t  result;
    int       failures;
    int       pending;
    int       sent;
    bit       idle_on;

    text_console_cell_writer_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    text_console_cell_writer_checker u_checker (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .request  (request),
        .done     (done),
        .result   (result),
        .failures (failures),
        .pending  (pending)
    );

    // 8 ns clock
    always
    begin
        #4;
        clk = 1'b1;
        #4;
        clk = 1'b0;
    end

    // Hard stop well past the slowest legal run
    initial
    begin
        #250_000_000;
        $display("text_console_cell_writer_unit test failed");
        $finish;
    end

    function automatic request_t make_req(logic [1:0] cmd, logic [7:0] ch, logic [7:0] at,
                                          logic [4:0] row, logic [6:0] col);
        request_t req;
        req.cmd       = cmd;
        req.char_code = ch;
        req.attr      = at;
        req.read_row  = row;
        req.read_col  = col;
        return req;
    endfunction

    // Mostly in-grid reads, some anywhere in the field range
    function automatic request_t read_req();
        logic [4:0] row;
        logic [6:0] col;
        row = ($urandom_range(0, 4) == 0) ? 5'($urandom) : 5'($urandom_range(0, ROWS - 1));
        col = ($urandom_range(0, 4) == 0) ? 7'($urandom) : 7'($urandom_range(0, COLUMNS - 1));
        return make_req(CMD_READ, 8'($urandom), 8'($urandom), row, col);
    endfunction

    function automatic request_t newline_req();
        return make_req(CMD_PUT, CH_NEWLINE, 8'($urandom), 5'($urandom), 7'($urandom));
    endfunction

    function automatic request_t return_req();
        return make_req(CMD_PUT, CH_RETURN, 8'($urandom), 5'($urandom), 7'($urandom));
    endfunction

    // Send one request, with an optional idle burst first; returns once it is accepted
    task automatic issue(request_t req);
        int gap;
        if (idle_on && sent < TAIL_START && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            gap = $urandom_range(1, 7);
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        request <= req;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sent++;
    endtask

    // Hold off until every outstanding result has come back
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // A line of text with the odd read mixed in, then a line ending
    task automatic text_line();
        int len;
        int term;
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 170) : $urandom_range(0, 24);
        for (int k = 0; k < len; k++)
        begin
            if ($urandom_range(0, 15) == 0)
                issue(read_req());
            else
                issue(make_req(CMD_PUT, 8'($urandom), 8'($urandom), 5'($urandom), 7'($urandom)));
        end
        term = $urandom_range(0, 19);
        if (term < 14)
            issue(newline_req());
        else if (term < 17)
        begin
            issue(return_req());
            issue(newline_req());
        end
        else if (term < 19)
            issue(return_req());
    endtask

    initial
    begin
        int pick;
        rst_n   = 1'b0;
        start   = 1'b0;
        request = '0;
        sent    = 0;
        idle_on = 1'b1;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset contents, byte extremes, line controls, reads off the grid,
        // the unused command, clear
        issue(make_req(CMD_READ, 8'h00, 8'h00, 5'd0, 7'd0));
        issue(make_req(CMD_READ, 8'hFF, 8'hFF, 5'd24, 7'd79));
        issue(make_req(CMD_PUT, 8'h41, 8'h1F, 5'd0, 7'd0));
        issue(make_req(CMD_PUT, 8'hFF, 8'h00, 5'd31, 7'd127));
        issue(make_req(CMD_PUT, 8'h00, 8'hFF, 5'd0, 7'd0));
        issue(make_req(CMD_PUT, 8'h80, 8'h80, 5'd16, 7'd64));
        issue(make_req(CMD_READ, 8'h00, 8'h00, 5'd0, 7'd0));
        issue(make_req(CMD_READ, 8'h00, 8'h00, 5'd0, 7'd1));
        issue(make_req(CMD_READ, 8'h00, 8'h00, 5'd0, 7'd2));
        issue(make_req(CMD_READ, 8'h00, 8'h00, 5'd0, 7'd3));
        issue(return_req());
        issue(newline_req());
        issue(make_req(CMD_PUT, 8'h7E, 8'h5A, 5'd0, 7'd0));
        issue(make_req(CMD_READ, 8'h00, 8'h00, 5'd1, 7'd0));
        issue(make_req(CMD_READ, 8'h00, 8'h00, 5'd25, 7'd0));
        issue(make_req(CMD_READ, 8'hFF, 8'hFF, 5'd31, 7'd127));
        issue(make_req(CMD_READ, 8'h00, 8'h00, 5'd0, 7'd80));
        issue(make_req(CMD_READ, 8'h00, 8'h00, 5'd24, 7'd127));
        issue(make_req(CMD_UNUSED, 8'hFF, 8'hFF, 5'd31, 7'd127));
        issue(make_req(CMD_CLEAR, 8'h55, 8'hAA, 5'd10, 7'd42));
        issue(make_req(CMD_READ, 8'h00, 8'h00, 5'd0, 7'd0));
        issue(make_req(CMD_READ, 8'h00, 8'h00, 5'd1, 7'd0));
        drain();

        // random: mostly text and line endings so the screen fills and scrolls
        while (sent < ITEM_TARGET)
        begin
            idle_on = ($urandom_range(0, 9) < 7);
            pick    = $urandom_range(0, 99);
            if (pick < 55)
                text_line();
            else if (pick < 70)
            begin
                // newline run to force scrolls, then look at the fresh bottom row
                repeat ($urandom_range(1, 30)) issue(newline_req());
                repeat (3) issue(make_req(CMD_READ, 8'($urandom), 8'($urandom), 5'(ROWS - 1),
                                          7'($urandom_range(0, COLUMNS - 1))));
            end
            else if (pick < 85)
                repeat ($urandom_range(1, 8)) issue(read_req());
            else if (pick < 97)
                repeat ($urandom_range(1, 6)) issue(make_req(2'($urandom), 8'($urandom),
                                                             8'($urandom), 5'($urandom),
                                                             7'($urandom)));
            else
            begin
                issue(make_req(CMD_CLEAR, 8'($urandom), 8'($urandom), 5'($urandom),
                               7'($urandom)));
                if ($urandom_range(0, 1) == 0)
                    drain();
            end
        end

        drain();
        repeat (40) @(posedge clk);
        if (failures == 0)
            $display("text_console_cell_writer_unit test passed");
        else
            $display("text_console_cell_writer_unit test failed");
        $finish;
    end

endmodule
